@@ rtl/matrix_to_quaternion_macros.svh @@
// Assertion macros used by the checker file.
`ifndef MATRIX_TO_QUATERNION_MACROS_SVH
`define MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, clocked on clk_i and held off during reset.
`define M2Q_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and held off during reset.
`define M2Q_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/m2q_pkg.sv @@
// ----------------------------------------------------------------------------
// m2q_pkg
// Shared constants for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package m2q_pkg;

  localparam int SampleWidthDef  = 16;
  localparam int FractionBitsDef = 14;

  // Which quaternion component comes from the square root.
  localparam logic [1:0] BIG_X = 2'd0;
  localparam logic [1:0] BIG_Y = 2'd1;
  localparam logic [1:0] BIG_Z = 2'd2;
  localparam logic [1:0] BIG_W = 2'd3;

  // Sideband layout flags before the per-lane fields.
  localparam int CtrlBits = 6;

endpackage

@@ rtl/m2q_isqrt.sv @@
// ----------------------------------------------------------------------------
// m2q_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module m2q_isqrt
  import m2q_pkg::*;
#(
  parameter int RADW = 32,
  parameter int RW   = 16,
  parameter int SBW  = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [RADW-1:0] rad_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SBW-1:0]  sb_o
);

  logic            v_q    [RW];
  logic [RW:0]     rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [RADW-1:0] rad_q  [RW];
  logic [SBW-1:0]  sb_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_s;
    logic [RW:0]     rem_s;
    logic [RW-1:0]   root_s;
    logic [RADW-1:0] rad_s;
    logic [SBW-1:0]  sb_s;
    logic [RW+1:0]   remx;
    logic [RW+1:0]   trial;
    logic [RW+1:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_s    = valid_i;
      assign rem_s  = '0;
      assign root_s = '0;
      assign rad_s  = rad_i;
      assign sb_s   = sb_i;
    end else begin : g_next
      assign v_s    = v_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
      assign rad_s  = rad_q[k-1];
      assign sb_s   = sb_q[k-1];
    end

    // Bring down the next two radicand bits and try 4*root + 1.
    assign remx  = {rem_s[RW-1:0], rad_s[RADW-1 -: 2]};
    assign trial = {root_s, 2'b01};
    assign ge    = (remx >= trial);
    assign diff  = remx - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[RW:0] : remx[RW:0];
        root_q[k] <= {root_s[RW-2:0], ge};
        rad_q[k]  <= rad_s << 2;
        sb_q[k]   <= sb_s;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign sb_o    = sb_q[RW-1];

endmodule

@@ rtl/m2q_div.sv @@
// ----------------------------------------------------------------------------
// m2q_div
// Three-lane pipelined restoring divider: round(mag * 2^F / (2R)), one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module m2q_div
  import m2q_pkg::*;
#(
  parameter int MW  = 17,
  parameter int F   = 14,
  parameter int RW  = 16,
  parameter int SBW = 8,
  localparam int NW = MW + F
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [MW-1:0]   mag0_i,
  input  logic [MW-1:0]   mag1_i,
  input  logic [MW-1:0]   mag2_i,
  input  logic [RW-1:0]   root_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            valid_o,
  output logic [NW-1:0]   quo0_o,
  output logic [NW-1:0]   quo1_o,
  output logic [NW-1:0]   quo2_o,
  output logic [RW-1:0]   root_o,
  output logic [SBW-1:0]  sb_o
);

  logic            v_q    [NW];
  logic [RW-1:0]   root_q [NW];
  logic [SBW-1:0]  sb_q   [NW];
  logic [NW-1:0]   num_q  [NW][3];
  logic [RW:0]     rem_q  [NW][3];
  logic [NW-1:0]   quo_q  [NW][3];

  // Adding R before dividing by 2R gives round half up on the magnitude.
  logic [NW-1:0] num_in [3];
  assign num_in[0] = (NW'(mag0_i) << F) + NW'(root_i);
  assign num_in[1] = (NW'(mag1_i) << F) + NW'(root_i);
  assign num_in[2] = (NW'(mag2_i) << F) + NW'(root_i);

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic           v_s;
    logic [RW-1:0]  root_s;
    logic [SBW-1:0] sb_s;
    logic [RW+1:0]  dvs;

    if (k == 0) begin : g_first
      assign v_s    = valid_i;
      assign root_s = root_i;
      assign sb_s   = sb_i;
    end else begin : g_next
      assign v_s    = v_q[k-1];
      assign root_s = root_q[k-1];
      assign sb_s   = sb_q[k-1];
    end

    assign dvs = {1'b0, root_s, 1'b0};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= root_s;
        sb_q[k]   <= sb_s;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [NW-1:0] num_s;
      logic [RW:0]   rem_s;
      logic [NW-1:0] quo_s;
      logic [RW+1:0] remx;
      logic [RW+1:0] diff;
      logic          ge;

      if (k == 0) begin : g_first
        assign num_s = num_in[l];
        assign rem_s = '0;
        assign quo_s = '0;
      end else begin : g_next
        assign num_s = num_q[k-1][l];
        assign rem_s = rem_q[k-1][l];
        assign quo_s = quo_q[k-1][l];
      end

      assign remx = {rem_s, num_s[NW-1]};
      assign ge   = (remx >= dvs);
      assign diff = remx - dvs;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          num_q[k][l] <= num_s << 1;
          rem_q[k][l] <= ge ? diff[RW:0] : remx[RW:0];
          quo_q[k][l] <= {quo_s[NW-2:0], ge};
        end
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo0_o  = quo_q[NW-1][0];
  assign quo1_o  = quo_q[NW-1][1];
  assign quo2_o  = quo_q[NW-1][2];
  assign root_o  = root_q[NW-1];
  assign sb_o    = sb_q[NW-1];

endmodule

@@ rtl/matrix_to_quaternion.sv @@
// Path: stage A, the square root and divider pipelines, then the output register.
// RW is half the padded radicand width; NW = W + F + 1 (31 at 16/14).
// Throughput: one transaction per cycle; the root and divider pipelines retire
// one bit per stage and all stages advance together unless the output stalls.
// Reset clears every valid bit; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// matrix_to_quaternion
// Converts a 3x3 fixed-point rotation matrix to a saturated quaternion.
// ----------------------------------------------------------------------------
module matrix_to_quaternion
  import m2q_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = SampleWidthDef,
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] m00_i,
  input  logic signed [SAMPLE_WIDTH-1:0] m01_i,
  input  logic signed [SAMPLE_WIDTH-1:0] m02_i,
  input  logic signed [SAMPLE_WIDTH-1:0] m10_i,
  input  logic signed [SAMPLE_WIDTH-1:0] m11_i,
  input  logic signed [SAMPLE_WIDTH-1:0] m12_i,
  input  logic signed [SAMPLE_WIDTH-1:0] m20_i,
  input  logic signed [SAMPLE_WIDTH-1:0] m21_i,
  input  logic signed [SAMPLE_WIDTH-1:0] m22_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] quat_x_o,
  output logic signed [SAMPLE_WIDTH-1:0] quat_y_o,
  output logic signed [SAMPLE_WIDTH-1:0] quat_z_o,
  output logic signed [SAMPLE_WIDTH-1:0] quat_w_o,
  output logic                           fault_o
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int F     = FRACTION_BITS;
  localparam int EW    = ((W > F + 1) ? W : F + 1) + 3;
  localparam int RADW  = EW - 1 + F;
  localparam int RADW2 = RADW + (RADW % 2);
  localparam int RW    = RADW2 / 2;
  localparam int NW    = W + F + 1;
  localparam int SBW   = CtrlBits + 3 * (W + 1);

  localparam logic signed [EW-1:0] ONE_E  = EW'(1) << F;
  localparam logic [NW-1:0]        SMAX_N = (NW'(1) << (W - 1)) - NW'(1);
  localparam logic [NW-1:0]        SMIN_N = NW'(1) << (W - 1);
  localparam logic [RW:0]          SMAX_R = (RW + 1)'(SMAX_N);
  localparam logic [W-1:0]         SMAX_W = SMAX_N[W-1:0];
  localparam logic [W-1:0]         SMIN_W = SMIN_N[W-1:0];

  logic en;
  logic out_valid_q;

  // The whole pipeline moves unless a finished result is held back.
  assign en      = !(out_valid_q && stall_i);
  assign stall_o = !en;

  // ---------------- Stage A: branch selection and root argument ----------------
  logic signed [EW-1:0] e00, e11, e22, trace, r_sel;
  logic signed [W:0]    f01, f02, f10, f12, f20, f21;
  logic signed [W:0]    s13, s26, s57, t75, t26, t31;
  logic signed [W:0]    d_sel [3];
  logic [1:0]           big_sel;

  assign e00 = EW'(m00_i);
  assign e11 = EW'(m11_i);
  assign e22 = EW'(m22_i);
  assign f01 = (W + 1)'(m01_i);
  assign f02 = (W + 1)'(m02_i);
  assign f10 = (W + 1)'(m10_i);
  assign f12 = (W + 1)'(m12_i);
  assign f20 = (W + 1)'(m20_i);
  assign f21 = (W + 1)'(m21_i);
  assign s13 = f01 + f10;
  assign s26 = f02 + f20;
  assign s57 = f12 + f21;
  assign t75 = f21 - f12;
  assign t26 = f02 - f20;
  assign t31 = f10 - f01;
  assign trace = e00 + e11 + e22;

  // Ties on the diagonal fall through to the later component.
  always_comb begin
    if (trace > 0) begin
      big_sel  = BIG_W;
      r_sel    = trace + ONE_E;
      d_sel[0] = t75;
      d_sel[1] = t26;
      d_sel[2] = t31;
    end else if (e00 > e11 && e00 > e22) begin
      big_sel  = BIG_X;
      r_sel    = ONE_E + e00 - e11 - e22;
      d_sel[0] = s13;
      d_sel[1] = s26;
      d_sel[2] = t75;
    end else if (e11 > e22) begin
      big_sel  = BIG_Y;
      r_sel    = ONE_E + e11 - e00 - e22;
      d_sel[0] = s13;
      d_sel[1] = s57;
      d_sel[2] = t26;
    end else begin
      big_sel  = BIG_Z;
      r_sel    = ONE_E + e22 - e00 - e11;
      d_sel[0] = s26;
      d_sel[1] = s57;
      d_sel[2] = t31;
    end
  end

  logic           va_q;
  logic [RADW2-1:0] rada_q;
  logic [SBW-1:0] sba_q;
  logic [W:0]     mag_a [3];

  // A sum of two full-scale negatives has a magnitude that needs W + 1 bits.
  for (genvar l = 0; l < 3; l++) begin : g_mag
    assign mag_a[l] = d_sel[l][W] ? (W + 1)'(-d_sel[l]) : (W + 1)'(d_sel[l]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rada_q <= RADW2'(r_sel[EW-2:0]) << F;
      sba_q  <= {big_sel, (r_sel[EW-1] || r_sel == '0),
                 d_sel[0][W], d_sel[1][W], d_sel[2][W],
                 mag_a[0], mag_a[1], mag_a[2]};
    end
  end

  // ---------------- Square root ----------------
  logic           vs;
  logic [RW-1:0]  root_s;
  logic [SBW-1:0] sb_s;

  m2q_isqrt #(
    .RADW (RADW2),
    .RW   (RW),
    .SBW  (SBW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va_q),
    .rad_i   (rada_q),
    .sb_i    (sba_q),
    .valid_o (vs),
    .root_o  (root_s),
    .sb_o    (sb_s)
  );

  // ---------------- Division ----------------
  logic                vd;
  logic [NW-1:0]       quo [3];
  logic [RW-1:0]       root_d;
  logic [CtrlBits-1:0] ctl_d;

  m2q_div #(
    .MW  (W + 1),
    .F   (F),
    .RW  (RW),
    .SBW (CtrlBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vs),
    .mag0_i  (sb_s[3*(W+1)-1 -: W+1]),
    .mag1_i  (sb_s[2*(W+1)-1 -: W+1]),
    .mag2_i  (sb_s[W:0]),
    .root_i  (root_s),
    .sb_i    (sb_s[SBW-1 -: CtrlBits]),
    .valid_o (vd),
    .quo0_o  (quo[0]),
    .quo1_o  (quo[1]),
    .quo2_o  (quo[2]),
    .root_o  (root_d),
    .sb_o    (ctl_d)
  );

  // ---------------- Saturation and output register ----------------
  logic [1:0]   big_d;
  logic         fault_d;
  logic [W-1:0] qs [3];
  logic [RW:0]  rc_full;
  logic [W-1:0] rc;
  logic [W-1:0] qx_d, qy_d, qz_d, qw_d;

  assign big_d   = ctl_d[5:4];
  assign fault_d = ctl_d[3];

  for (genvar l = 0; l < 3; l++) begin : g_sat
    always_comb begin
      if (!ctl_d[2-l]) begin
        qs[l] = (quo[l] > SMAX_N) ? SMAX_W : quo[l][W-1:0];
      end else begin
        qs[l] = (quo[l] > SMIN_N) ? SMIN_W : W'(-quo[l][W-1:0]);
      end
    end
  end

  assign rc_full = ((RW + 1)'(root_d) + (RW + 1)'(1)) >> 1;
  assign rc      = (rc_full > SMAX_R) ? SMAX_W : rc_full[W-1:0];

  always_comb begin
    case (big_d)
      BIG_X: begin
        qx_d = rc;    qy_d = qs[0]; qz_d = qs[1]; qw_d = qs[2];
      end
      BIG_Y: begin
        qx_d = qs[0]; qy_d = rc;    qz_d = qs[1]; qw_d = qs[2];
      end
      BIG_Z: begin
        qx_d = qs[0]; qy_d = qs[1]; qz_d = rc;    qw_d = qs[2];
      end
      default: begin
        qx_d = qs[0]; qy_d = qs[1]; qz_d = qs[2]; qw_d = rc;
      end
    endcase
    if (fault_d) begin
      qx_d = '0;
      qy_d = '0;
      qz_d = '0;
      qw_d = '0;
    end
  end

  logic [W-1:0] qx_q, qy_q, qz_q, qw_q;
  logic         fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q    <= qx_d;
      qy_q    <= qy_d;
      qz_q    <= qz_d;
      qw_q    <= qw_d;
      fault_q <= fault_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign quat_x_o = qx_q;
  assign quat_y_o = qy_q;
  assign quat_z_o = qz_q;
  assign quat_w_o = qw_q;
  assign fault_o  = fault_q;

endmodule

@@ rtl/m2q_checker.sv @@
// ----------------------------------------------------------------------------
// m2q_checker
// Port-level checks for the matrix to quaternion converter.
// ----------------------------------------------------------------------------
`include "matrix_to_quaternion_macros.svh"

module m2q_checker
  import m2q_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SampleWidthDef
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           valid_i,
  input logic                           stall_o,
  input logic                           valid_o,
  input logic                           stall_i,
  input logic signed [SAMPLE_WIDTH-1:0] quat_x_o,
  input logic signed [SAMPLE_WIDTH-1:0] quat_y_o,
  input logic signed [SAMPLE_WIDTH-1:0] quat_z_o,
  input logic signed [SAMPLE_WIDTH-1:0] quat_w_o,
  input logic                           fault_o
);

  // A faulted transaction carries an all-zero quaternion.
  `M2Q_ASSERT_IMP(a_fault_zero, valid_o && fault_o,
    quat_x_o == '0 && quat_y_o == '0 && quat_z_o == '0 && quat_w_o == '0,
    "fault result with nonzero quaternion")

  // The input only backs up when a finished result is being held.
  `M2Q_ASSERT_IMP(a_stall_cause, stall_o, valid_o && stall_i,
    "input stalled without a held output")

  // A held result stays put while the receiver stalls; x, w and fault are checked.
  `M2Q_ASSERT_NXT(a_out_hold, valid_o && stall_i,
    valid_o && $stable(quat_x_o) && $stable(quat_w_o) && $stable(fault_o),
    "held output changed")

  // An empty output register never backs up the input.
  `M2Q_ASSERT_IMP(a_idle_quiet, !valid_o, !stall_o,
    "stall raised from an idle output")

endmodule

bind matrix_to_quaternion m2q_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_m2q_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Matrix to quaternion converter testbench
// Drives 3x3 Q2.14 matrices through the converter under random sender and
// receiver idling, predicts each quaternion with an integer model of the
// trace-first branch selection, and compares every field of every result.
// ----------------------------------------------------------------------------
module tb_top;
  import m2q_pkg::*;

  localparam int SW = SampleWidthDef;
  localparam int FB = FractionBitsDef;
  localparam int NRAND = 1400;

  typedef logic signed [SW-1:0] sample_t;
  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
    sample_t w;
    logic    fault;
  } quat_t;

  logic    clk_i, rst_ni;
  logic    valid_i, stall_o, valid_o, stall_i, fault_o;
  sample_t m_i [9];
  sample_t quat_x_o, quat_y_o, quat_z_o, quat_w_o;

  quat_t   quat_queue [$];
  int      mismatches;
  int      send_idle_pct, recv_idle_pct;

  matrix_to_quaternion dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .m00_i   (m_i[0]),
    .m01_i   (m_i[1]),
    .m02_i   (m_i[2]),
    .m10_i   (m_i[3]),
    .m11_i   (m_i[4]),
    .m12_i   (m_i[5]),
    .m20_i   (m_i[6]),
    .m21_i   (m_i[7]),
    .m22_i   (m_i[8]),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .quat_x_o(quat_x_o),
    .quat_y_o(quat_y_o),
    .quat_z_o(quat_z_o),
    .quat_w_o(quat_w_o),
    .fault_o (fault_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint sat_sample(longint v);
    longint hi;
    hi = (longint'(1) << (SW - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res;
    longint b;
    res = 0;
    b = longint'(1) << 60;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // Quotient d * 2^FB / (2 * root), rounded half away from zero.
  function automatic longint scaled_div(longint d, longint root);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = ((mag <<< FB) + root) / (root * 2);
    return (d < 0) ? -q : q;
  endfunction

  function automatic quat_t predict_quat(sample_t mat [9]);
    longint a [9];
    longint comp [4];
    longint ds [3];
    longint one, tr, r, root;
    logic [1:0] big;
    quat_t res;
    int k;
    for (int i = 0; i < 9; i++) a[i] = mat[i];
    for (int i = 0; i < 4; i++) comp[i] = 0;
    one = longint'(1) << FB;
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      big = BIG_W;
      r = tr + one;
      ds[0] = a[7] - a[5]; ds[1] = a[2] - a[6]; ds[2] = a[3] - a[1];
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      big = BIG_X;
      r = one + a[0] - a[4] - a[8];
      ds[0] = a[1] + a[3]; ds[1] = a[2] + a[6]; ds[2] = a[7] - a[5];
    end else if (a[4] > a[8]) begin
      big = BIG_Y;
      r = one + a[4] - a[0] - a[8];
      ds[0] = a[1] + a[3]; ds[1] = a[5] + a[7]; ds[2] = a[2] - a[6];
    end else begin
      big = BIG_Z;
      r = one + a[8] - a[0] - a[4];
      ds[0] = a[2] + a[6]; ds[1] = a[5] + a[7]; ds[2] = a[3] - a[1];
    end
    res.fault = (r <= 0);
    if (!res.fault) begin
      root = int_sqrt(r <<< FB);
      comp[big] = (root + 1) >>> 1;
      k = 0;
      for (int i = 0; i < 4; i++) begin
        if (i != big) begin
          comp[i] = scaled_div(ds[k], root);
          k++;
        end
      end
    end
    res.x = sample_t'(sat_sample(comp[0]));
    res.y = sample_t'(sat_sample(comp[1]));
    res.z = sample_t'(sat_sample(comp[2]));
    res.w = sample_t'(sat_sample(comp[3]));
    return res;
  endfunction

  // Sends one matrix; called at a falling edge and returns at a falling edge.
  // Valid stays high on return so that the next transaction can follow at once.
  task automatic send_matrix(sample_t mat [9]);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    for (int i = 0; i < 9; i++) m_i[i] <= mat[i];
    quat_queue.push_back(predict_quat(mat));
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) stall_i <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    quat_t exp_q;
    if (rst_ni && valid_o && !stall_i) begin
      if (quat_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transaction: x=%0d", quat_x_o);
      end else begin
        exp_q = quat_queue.pop_front();
        if (exp_q.x !== quat_x_o || exp_q.y !== quat_y_o || exp_q.z !== quat_z_o ||
            exp_q.w !== quat_w_o || exp_q.fault !== fault_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d %0d %0d %0d f%0b, got %0d %0d %0d %0d f%0b",
                     exp_q.x, exp_q.y, exp_q.z, exp_q.w, exp_q.fault,
                     quat_x_o, quat_y_o, quat_z_o, quat_w_o, fault_o);
        end
      end
    end
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(5))
      0: return sample_t'($urandom);
      1: return sample_t'(16'sh7fff);
      2: return sample_t'(16'sh8000);
      3: return sample_t'($urandom_range(800) - 400);
      default: return sample_t'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic send_diag(int d0, int d1, int d2, int off);
    sample_t mat [9];
    for (int i = 0; i < 9; i++) mat[i] = sample_t'(off * (i + 1));
    mat[0] = sample_t'(d0); mat[4] = sample_t'(d1); mat[8] = sample_t'(d2);
    send_matrix(mat);
  endtask

  task automatic test_directed();
    sample_t mat [9];
    send_diag(16384, 16384, 16384, 0);      // identity, trace branch
    send_diag(16384, -16384, -16384, 0);    // x from the root
    send_diag(-16384, 16384, -16384, 0);    // y from the root
    send_diag(-16384, -16384, 16384, 0);    // z from the root
    send_diag(0, 0, 0, 0);                  // zero trace, ties fall to z
    send_diag(-100, -100, -200, 37);        // tie between x and y picks y
    send_diag(5, -100, 5, -91);             // tie between x and z picks z
    send_diag(-32768, -32768, -32768, 0);   // full-scale negative diagonal, z branch
    send_diag(-8192, -8192, -16384, 0);     // y branch, root argument 32768
    send_diag(32767, 32767, 32767, 32767);  // full-scale positive diagonal
    send_diag(-32768, 32767, -32768, -32768);
    send_diag(1, 0, 0, 1);
    send_diag(-16384, 0, 16384, -1);
    for (int i = 0; i < 9; i++) mat[i] = sample_t'(16'sh7fff);
    send_matrix(mat);
    for (int i = 0; i < 9; i++) mat[i] = sample_t'(16'sh8000);
    send_matrix(mat);
    for (int i = 0; i < 9; i++) mat[i] = sample_t'(16'sh5555 ^ (i[0] ? 16'hffff : 0));
    send_matrix(mat);
  endtask

  task automatic test_random(int count);
    sample_t mat [9];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 9; i++) mat[i] = rand_sample();
      send_matrix(mat);
    end
  endtask

  task automatic wait_drain();
    valid_i <= 1'b0;
    while (quat_queue.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  initial begin
    mismatches = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    stall_i = 1'b0;
    for (int i = 0; i < 9; i++) m_i[i] = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_idle_pct = 33;
    recv_idle_pct = 61;
    test_directed();
    test_random(NRAND / 3);
    send_idle_pct = 61;
    recv_idle_pct = 33;
    test_random(NRAND / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(NRAND - 2 * (NRAND / 3));
    wait_drain();
    if (mismatches == 0 && quat_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ matrix_to_quaternion.f @@
+incdir+rtl
rtl/m2q_pkg.sv
rtl/m2q_isqrt.sv
rtl/m2q_div.sv
rtl/matrix_to_quaternion.sv
rtl/m2q_checker.sv
tb/tb_top.sv
